[design/amfea_pkg.sv]
// Shared types and constants for the alpha mask feather/expand/apply block.
// Used by the divider and the top level; no dependencies.
package amfea_pkg;

  localparam int unsigned Q15_W = 16;
  localparam logic [Q15_W-1:0] ONE_Q15 = 16'd32768;
  localparam logic [31:0] HALF_Q15 = 32'd16384;

  localparam logic [2:0] REG_REGION_WIDTH = 3'd0;
  localparam logic [2:0] REG_REGION_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FEATHER_RADIUS = 3'd2;
  localparam logic [2:0] REG_GROW_RADIUS = 3'd3;
  localparam logic [2:0] REG_FLIP_MASK = 3'd4;

  typedef struct packed {
    logic done;
    logic [Q15_W-1:0] quot;
  } div_res_t;

endpackage

[design/amfea_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on amfea_pkg for the result struct.
module amfea_div #(
  parameter int unsigned SW = 21,
  parameter int unsigned CW = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SW-1:0]      dividend_i,
  input  logic [CW-1:0]      divisor_i,
  output amfea_pkg::div_res_t res_o
);
  import amfea_pkg::*;

  localparam int unsigned NW = $clog2(SW + 1);

  logic [SW-1:0] dvd_q;
  logic [CW:0]   rem_q;
  logic [CW-1:0] dsr_q;
  logic [NW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [CW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_q[CW-1:0], dvd_q[SW-1]};
  assign ge = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q <= '0;
      rem_q <= '0;
      dsr_q <= '0;
      cnt_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dvd_q <= dividend_i;
        dsr_q <= divisor_i;
        rem_q <= '0;
        cnt_q <= NW'(SW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? rem_sh - {1'b0, dsr_q} : rem_sh;
        dvd_q <= {dvd_q[SW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == NW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = dvd_q[Q15_W-1:0];

endmodule

[design/alpha_mask_feather_expand_apply.sv]
// Top level: frame stores, mask refinement sequencer, fetch multiply, APB registers.
// Depends on amfea_pkg and amfea_div.
//
// Usage: items enter on the in channel (valid/stall). kind 0 loads one source
// and mask opacity in raster order and gives no result; kind 1 fetches the
// next result pixel, one item on the out channel. The APB port sets region
// size, feather radius, grow radius and invert; the user is to write them
// only while the block is idle, the block itself does not enforce it. The
// load that fills the region starts the mask refinement if a feather or grow
// radius is set: each blur pass reads every tap through the shared store read
// address and then runs a one-bit-per-cycle divider, dilation or erosion reads
// every tap of the window, and the input stays stalled for the whole run.
// A fetch goes through store read, multiply and output register.
// A fetch before the region is refined returns not_ready at once.
// Reset clears counters and control; stores are not cleared, every entry is
// written before it is read. A stalled result holds in the output register
// and the input stalls until it is taken.
module alpha_mask_feather_expand_apply #(
  parameter int unsigned MAX_WIDTH = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_RADIUS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [15:0] source_opacity_i,
  input  logic [15:0] mask_opacity_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] result_opacity_o,
  output logic        last_of_frame_o,
  output logic        not_ready_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import amfea_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned TW = $clog2(DEPTH + 1);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = $clog2(MAX_RADIUS + 1);
  localparam int unsigned XW = ((WW > HW ? WW : HW) > RW ? (WW > HW ? WW : HW) : RW) + 1;
  localparam int unsigned CW = $clog2(2 * MAX_RADIUS + 2);
  localparam int unsigned SW = Q15_W + $clog2(2 * MAX_RADIUS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_ADDR, S_RD, S_ACC, S_DIV_GO, S_DIV_WAIT, S_WR,
    S_F_RD, S_F_MUL, S_F_OUT
  } state_e;

  typedef enum logic [1:0] {PH_HB, PH_VB, PH_GR} phase_e;

  // configuration
  logic [8:0] cfg_w_q, cfg_h_q;
  logic [3:0] cfg_fr_q;
  logic [4:0] cfg_gr_q;
  logic       cfg_flip_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= 9'd256;
      cfg_h_q <= 9'd256;
      cfg_fr_q <= '0;
      cfg_gr_q <= '0;
      cfg_flip_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_REGION_WIDTH:   cfg_w_q <= pwdata[8:0];
        REG_REGION_HEIGHT:  cfg_h_q <= pwdata[8:0];
        REG_FEATHER_RADIUS: cfg_fr_q <= pwdata[3:0];
        REG_GROW_RADIUS:    cfg_gr_q <= pwdata[4:0];
        REG_FLIP_MASK:      cfg_flip_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_REGION_WIDTH:   prdata = {23'd0, cfg_w_q};
      REG_REGION_HEIGHT:  prdata = {23'd0, cfg_h_q};
      REG_FEATHER_RADIUS: prdata = {28'd0, cfg_fr_q};
      REG_GROW_RADIUS:    prdata = {27'd0, cfg_gr_q};
      REG_FLIP_MASK:      prdata = {31'd0, cfg_flip_q};
      default:            prdata = '0;
    endcase
  end

  // effective load-time settings
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [TW-1:0] total_eff;
  logic [RW-1:0] fr_eff, gr_eff;
  logic [5:0]    gr_mag;

  assign w_eff = (cfg_w_q == 9'd0) ? WW'(1) :
                 (32'(cfg_w_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_w_q);
  assign h_eff = (cfg_h_q == 9'd0) ? HW'(1) :
                 (32'(cfg_h_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_h_q);
  assign total_eff = TW'((TW + WW)'(w_eff) * (TW + WW)'(h_eff));
  assign fr_eff = (32'(cfg_fr_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg_fr_q);
  assign gr_mag = cfg_gr_q[4] ? 6'(6'd32 - {1'b0, cfg_gr_q}) : {1'b0, cfg_gr_q};
  assign gr_eff = (32'(gr_mag) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(gr_mag);

  // state
  state_e        state_q;
  phase_e        phase_q;
  logic [TW-1:0] loaded_q, fetched_q, total_q;
  logic          done_q, res_scr_q, flip_q, dil_q, grow_q;
  logic [WW-1:0] w_q, x_q, tx_q, xs_q, xe_q;
  logic [HW-1:0] h_q, y_q, ty_q, ye_q;
  logic [RW-1:0] fr_q, gr_q;
  logic [AW-1:0] pix_q, ta_q, rb_q;
  logic [SW-1:0] acc_q;
  logic [CW-1:0] cnt_q;
  logic [15:0]   wval_q;
  logic [31:0]   prod_q;
  logic          out_vld_q, out_last_q, out_nr_q;
  logic [15:0]   out_res_q;

  // stores
  logic [15:0] src_mem [DEPTH];
  logic [15:0] msk_mem [DEPTH];
  logic [15:0] scr_mem [DEPTH];
  logic [15:0] src_rd_q, msk_rd_q, scr_rd_q;
  logic [AW-1:0] rd_addr;
  logic        ld_we, msk_we, scr_we;
  logic [15:0] msk_wd, src_wd, ld_msk;
  logic [AW-1:0] msk_wa;

  logic in_acc;
  assign in_stall_o = (state_q != S_IDLE) || (out_vld_q && out_stall_i);
  assign in_acc = in_valid_i && !in_stall_o;

  assign src_wd = (source_opacity_i > ONE_Q15) ? ONE_Q15 : source_opacity_i;
  assign ld_msk = (mask_opacity_i > ONE_Q15) ? ONE_Q15 : mask_opacity_i;
  assign ld_we = in_acc && !kind_i && !done_q && (loaded_q < total_eff);
  assign msk_we = ld_we || (state_q == S_WR && phase_q == PH_VB);
  assign msk_wa = ld_we ? loaded_q[AW-1:0] : pix_q;
  assign msk_wd = ld_we ? ld_msk : wval_q;
  assign scr_we = (state_q == S_WR) && (phase_q != PH_VB);
  assign rd_addr = (state_q == S_F_RD) ? fetched_q[AW-1:0] : ta_q;

  always_ff @(posedge clk_i) begin
    if (ld_we) src_mem[loaded_q[AW-1:0]] <= src_wd;
    src_rd_q <= src_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (msk_we) msk_mem[msk_wa] <= msk_wd;
    msk_rd_q <= msk_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (scr_we) scr_mem[pix_q] <= wval_q;
    scr_rd_q <= scr_mem[rd_addr];
  end

  // window bounds
  logic [RW-1:0] rx, ry;
  logic [XW-1:0] xe_full, ye_full;
  logic [WW-1:0] xs_c, xe_c;
  logic [HW-1:0] ys_c, ye_c;
  logic [HW+WW-1:0] rb_prod;

  always_comb begin
    unique case (phase_q)
      PH_HB:   begin rx = fr_q; ry = '0; end
      PH_VB:   begin rx = '0; ry = fr_q; end
      default: begin rx = gr_q; ry = gr_q; end
    endcase
  end

  assign xs_c = (XW'(x_q) >= XW'(rx)) ? WW'(XW'(x_q) - XW'(rx)) : '0;
  assign ys_c = (XW'(y_q) >= XW'(ry)) ? HW'(XW'(y_q) - XW'(ry)) : '0;
  assign xe_full = XW'(x_q) + XW'(rx);
  assign ye_full = XW'(y_q) + XW'(ry);
  assign xe_c = (xe_full >= XW'(w_q) - XW'(1)) ? WW'(w_q - 1'b1) : WW'(xe_full);
  assign ye_c = (ye_full >= XW'(h_q) - XW'(1)) ? HW'(h_q - 1'b1) : HW'(ye_full);
  assign rb_prod = (HW + WW)'(ys_c) * (HW + WW)'(w_q);

  // tap datapath
  logic [15:0] tap;
  logic        take;
  assign tap = (phase_q == PH_VB) ? scr_rd_q : msk_rd_q;
  assign take = dil_q ? (SW'(tap) > acc_q) : (SW'(tap) < acc_q);

  logic [AW-1:0] rb_next;
  assign rb_next = AW'(rb_q + AW'(w_q));

  // divider
  div_res_t div_res;
  logic     div_go;
  logic [SW-1:0] div_dvd;
  assign div_go = (state_q == S_DIV_GO);
  assign div_dvd = acc_q + SW'(cnt_q >> 1);

  amfea_div #(.SW(SW), .CW(CW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (div_dvd),
    .divisor_i  (cnt_q),
    .res_o      (div_res)
  );

  // fetch datapath
  logic [15:0] fm_raw, fm;
  logic [31:0] fprod;
  logic [TW-1:0] loaded_nx;
  assign fm_raw = res_scr_q ? scr_rd_q : msk_rd_q;
  assign fm = flip_q ? 16'(ONE_Q15 - fm_raw) : fm_raw;
  assign fprod = 32'(src_rd_q) * 32'(fm);
  assign loaded_nx = (loaded_q < total_eff) ? TW'(loaded_q + 1'b1) : loaded_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_HB;
      loaded_q <= '0;
      fetched_q <= '0;
      total_q <= '0;
      done_q <= 1'b0;
      res_scr_q <= 1'b0;
      flip_q <= 1'b0;
      dil_q <= 1'b0;
      grow_q <= 1'b0;
      w_q <= '0;
      h_q <= '0;
      fr_q <= '0;
      gr_q <= '0;
      x_q <= '0;
      y_q <= '0;
      tx_q <= '0;
      ty_q <= '0;
      xs_q <= '0;
      xe_q <= '0;
      ye_q <= '0;
      pix_q <= '0;
      ta_q <= '0;
      rb_q <= '0;
      acc_q <= '0;
      cnt_q <= '0;
      wval_q <= '0;
      prod_q <= '0;
      out_vld_q <= 1'b0;
      out_last_q <= 1'b0;
      out_nr_q <= 1'b0;
      out_res_q <= '0;
    end else begin
      if (out_vld_q && !out_stall_i) out_vld_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && kind_i) begin
            if (!done_q || fetched_q >= total_q) begin
              out_vld_q <= 1'b1;
              out_res_q <= '0;
              out_last_q <= 1'b0;
              out_nr_q <= 1'b1;
            end else begin
              state_q <= S_F_RD;
            end
          end else if (in_acc && !done_q) begin
            loaded_q <= loaded_nx;
            if (loaded_nx >= total_eff) begin
              w_q <= w_eff;
              h_q <= h_eff;
              total_q <= total_eff;
              fr_q <= fr_eff;
              gr_q <= gr_eff;
              dil_q <= !cfg_gr_q[4];
              grow_q <= (cfg_gr_q != 5'd0);
              flip_q <= cfg_flip_q;
              res_scr_q <= (cfg_gr_q != 5'd0);
              x_q <= '0;
              y_q <= '0;
              pix_q <= '0;
              if (fr_eff != '0) begin
                phase_q <= PH_HB;
                state_q <= S_SETUP;
              end else if (cfg_gr_q != 5'd0) begin
                phase_q <= PH_GR;
                state_q <= S_SETUP;
              end else begin
                done_q <= 1'b1;
              end
            end
          end
        end
        S_SETUP: begin
          xs_q <= xs_c;
          xe_q <= xe_c;
          ye_q <= ye_c;
          ty_q <= ys_c;
          rb_q <= AW'(rb_prod);
          state_q <= S_ADDR;
        end
        S_ADDR: begin
          ta_q <= AW'(rb_q + AW'(xs_q));
          tx_q <= xs_q;
          cnt_q <= '0;
          acc_q <= (phase_q == PH_GR && !dil_q) ? SW'(ONE_Q15) : '0;
          state_q <= S_RD;
        end
        S_RD: state_q <= S_ACC;
        S_ACC: begin
          if (phase_q == PH_GR) begin
            if (take) acc_q <= SW'(tap);
          end else begin
            acc_q <= acc_q + SW'(tap);
            cnt_q <= cnt_q + 1'b1;
          end
          state_q <= S_RD;
          if (tx_q == xe_q) begin
            if (ty_q == ye_q) begin
              state_q <= (phase_q == PH_GR) ? S_WR : S_DIV_GO;
            end else begin
              ty_q <= ty_q + 1'b1;
              rb_q <= rb_next;
              ta_q <= AW'(rb_next + AW'(xs_q));
              tx_q <= xs_q;
            end
          end else begin
            tx_q <= tx_q + 1'b1;
            ta_q <= ta_q + 1'b1;
          end
          if (phase_q == PH_GR) wval_q <= take ? tap : acc_q[15:0];
        end
        S_DIV_GO: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_res.done) begin
            wval_q <= div_res.quot;
            state_q <= S_WR;
          end
        end
        S_WR: begin
          pix_q <= pix_q + 1'b1;
          state_q <= S_SETUP;
          if (x_q == WW'(w_q - 1'b1)) begin
            x_q <= '0;
            if (y_q == HW'(h_q - 1'b1)) begin
              y_q <= '0;
              pix_q <= '0;
              if (phase_q == PH_HB) begin
                phase_q <= PH_VB;
              end else if (phase_q == PH_VB && grow_q) begin
                phase_q <= PH_GR;
              end else begin
                done_q <= 1'b1;
                state_q <= S_IDLE;
              end
            end else begin
              y_q <= y_q + 1'b1;
            end
          end else begin
            x_q <= x_q + 1'b1;
          end
        end
        S_F_RD: state_q <= S_F_MUL;
        S_F_MUL: begin
          prod_q <= fprod;
          state_q <= S_F_OUT;
        end
        S_F_OUT: begin
          out_vld_q <= 1'b1;
          out_res_q <= 16'((prod_q + HALF_Q15) >> 15);
          out_nr_q <= 1'b0;
          out_last_q <= (TW'(fetched_q + 1'b1) == total_q);
          if (TW'(fetched_q + 1'b1) == total_q) begin
            fetched_q <= '0;
            loaded_q <= '0;
            done_q <= 1'b0;
          end else begin
            fetched_q <= fetched_q + 1'b1;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_opacity_o = out_res_q;
  assign last_of_frame_o = out_last_q;
  assign not_ready_o = out_nr_q;

  a_fetch_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_F_OUT |-> !out_vld_q)
    else $error("fetch result would overwrite a pending item");

  a_last_not_nr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_last_q |-> !out_nr_q)
    else $error("last item flagged not ready");

  a_fetch_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> fetched_q < total_q)
    else $error("fetch index beyond frame");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ACC |=> in_stall_o)
    else $error("input accepted during refinement");

endmodule

[tb/alpha_mask_feather_expand_apply_tb.sv]
// Testbench for alpha_mask_feather_expand_apply: loads frames, fetches results,
// and checks them against a scoreboard with its own mask refinement.
// Depends on amfea_pkg and the block's RTL.
`timescale 1ns / 100ps

module alpha_mask_feather_expand_apply_tb;
  import amfea_pkg::*;

  typedef struct packed {
    logic [15:0] opacity;
    logic        last;
    logic        not_ready;
  } pixel_out_t;

  class opacity_scoreboard;
    logic [15:0] src_px[65536];
    logic [15:0] msk_px[65536];
    logic [15:0] tmp_px[65536];
    int unsigned loaded, fetched, frame_px;
    bit          refined;
    logic [8:0]  width_r = 9'd256;
    logic [8:0]  height_r = 9'd256;
    logic [3:0]  feather_r = 4'd0;
    logic [4:0]  grow_r = 5'd0;
    bit          flip_r;
    pixel_out_t  pending[$];
    int          errors;

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_REGION_WIDTH:   width_r = v[8:0];
        REG_REGION_HEIGHT:  height_r = v[8:0];
        REG_FEATHER_RADIUS: feather_r = v[3:0];
        REG_GROW_RADIUS:    grow_r = v[4:0];
        REG_FLIP_MASK:      flip_r = v[0];
        default: ;
      endcase
    endfunction

    function int clamp_dim(int v);
      return v < 1 ? 1 : (v > 256 ? 256 : v);
    endfunction

    function void blur(int w, int h, int r);
      int sum, cnt, sx;
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          sum = 0; cnt = 0;
          for (int d = -r; d <= r; d++) begin
            sx = x + d;
            if (sx >= 0 && sx < w) begin sum += msk_px[y*w+sx]; cnt++; end
          end
          tmp_px[y*w+x] = 16'((sum + cnt/2) / cnt);
        end
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          sum = 0; cnt = 0;
          for (int d = -r; d <= r; d++) begin
            sx = y + d;
            if (sx >= 0 && sx < h) begin sum += tmp_px[sx*w+x]; cnt++; end
          end
          msk_px[y*w+x] = 16'((sum + cnt/2) / cnt);
        end
    endfunction

    function void grow(int w, int h, int r, bit dilate);
      logic [15:0] v, a;
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          v = dilate ? 16'd0 : ONE_Q15;
          for (int dy = -r; dy <= r; dy++)
            for (int dx = -r; dx <= r; dx++)
              if (y+dy >= 0 && y+dy < h && x+dx >= 0 && x+dx < w) begin
                a = msk_px[(y+dy)*w+x+dx];
                if (dilate ? (a > v) : (a < v)) v = a;
              end
          tmp_px[y*w+x] = v;
        end
      for (int i = 0; i < w*h; i++) msk_px[i] = tmp_px[i];
    endfunction

    function void refine(int w, int h);
      int g;
      g = $signed(grow_r);
      if (feather_r != 0) blur(w, h, int'(feather_r));
      if (g > 0) grow(w, h, g > 15 ? 15 : g, 1'b1);
      else if (g < 0) grow(w, h, -g > 15 ? 15 : -g, 1'b0);
      if (flip_r)
        for (int i = 0; i < w*h; i++) msk_px[i] = ONE_Q15 - msk_px[i];
      frame_px = w * h;
      refined = 1;
    endfunction

    function void note_item(logic kind, logic [15:0] s, logic [15:0] m);
      int w, h;
      pixel_out_t p;
      logic [31:0] prod;
      if (!kind) begin
        if (refined) return;
        w = clamp_dim(int'(width_r));
        h = clamp_dim(int'(height_r));
        if (loaded < w*h) begin
          src_px[loaded] = s > ONE_Q15 ? ONE_Q15 : s;
          msk_px[loaded] = m > ONE_Q15 ? ONE_Q15 : m;
          loaded++;
        end
        if (loaded >= w*h) refine(w, h);
        return;
      end
      if (!refined || fetched >= frame_px) begin
        p = '{opacity: 16'd0, last: 1'b0, not_ready: 1'b1};
      end else begin
        prod = src_px[fetched] * msk_px[fetched];
        p.opacity = 16'((prod + HALF_Q15) >> 15);
        p.last = (fetched + 1 == frame_px);
        p.not_ready = 1'b0;
        fetched++;
        if (p.last) begin loaded = 0; fetched = 0; refined = 0; end
      end
      pending.push_back(p);
    endfunction

    function void check_result(logic [15:0] opacity, logic last, logic nr);
      pixel_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result opacity=%0d", opacity);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (opacity !== e.opacity) begin
        $error("result_opacity expected %0d got %0d", e.opacity, opacity); errors++;
      end
      if (last !== e.last) begin
        $error("last_of_frame expected %0d got %0d", e.last, last); errors++;
      end
      if (nr !== e.not_ready) begin
        $error("not_ready expected %0d got %0d", e.not_ready, nr); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        kind = 0;
  logic [15:0] source_opacity = 0;
  logic [15:0] mask_opacity = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [15:0] result_opacity;
  logic        last_of_frame;
  logic        not_ready;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [4:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  opacity_scoreboard sb = new();
  bit quiet = 0;
  int items_sent = 0;
  int idle_cycles = 0;

  alpha_mask_feather_expand_apply dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .kind_i(kind),
    .source_opacity_i(source_opacity), .mask_opacity_i(mask_opacity),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .result_opacity_o(result_opacity), .last_of_frame_o(last_of_frame),
    .not_ready_o(not_ready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(kind, source_opacity, mask_opacity);
      if (out_valid && !out_stall) sb.check_result(result_opacity, last_of_frame, not_ready);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 400000) begin
        $display("alpha_mask_feather_expand_apply: mismatch");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      if (quiet || $urandom_range(0, 3) == 0) begin
        out_stall <= 0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_stall <= 1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic apb_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    sb.write_reg(idx, v);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic send(logic k, logic [15:0] s, logic [15:0] m);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1; kind <= k; source_opacity <= s; mask_opacity <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_opacity();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return ONE_Q15;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic setup(logic [8:0] w, logic [8:0] h, logic [3:0] fr, logic [4:0] gr,
                       logic fl);
    apb_write(REG_REGION_WIDTH, 32'(w));
    apb_write(REG_REGION_HEIGHT, 32'(h));
    apb_write(REG_FEATHER_RADIUS, 32'(fr));
    apb_write(REG_GROW_RADIUS, 32'(gr));
    apb_write(REG_FLIP_MASK, 32'(fl));
  endtask

  task automatic run_frame(logic [8:0] w, logic [8:0] h, logic [3:0] fr, logic [4:0] gr,
                           logic fl, bit noisy);
    int n;
    setup(w, h, fr, gr, fl);
    n = sb.clamp_dim(int'(w)) * sb.clamp_dim(int'(h));
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) send(1'b1, rand_opacity(), rand_opacity());
      send(1'b0, rand_opacity(), rand_opacity());
    end
    if (noisy && $urandom_range(0, 3) == 0) send(1'b0, rand_opacity(), rand_opacity());
    for (int i = 0; i < n; i++) send(1'b1, rand_opacity(), rand_opacity());
    if (noisy && $urandom_range(0, 3) == 0) send(1'b1, 16'hffff, 16'hffff);
    settle();
  endtask

  initial begin
    logic [8:0] w, h;
    logic [3:0] fr;
    logic [4:0] gr;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(1'b1, 16'd0, 16'd0);
    settle();
    setup(9'd2, 9'd2, 4'd0, 5'd0, 1'b0);
    send(1'b0, 16'd0, 16'hffff);
    send(1'b0, ONE_Q15, ONE_Q15);
    send(1'b0, 16'hffff, 16'd0);
    send(1'b0, 16'h8001, 16'h7fff);
    send(1'b0, 16'h1234, 16'h1234);
    for (int i = 0; i < 5; i++) send(1'b1, 16'd0, 16'd0);
    settle();

    setup(9'd3, 9'd3, 4'd0, 5'd0, 1'b0);
    for (int i = 0; i < 4; i++) send(1'b0, rand_opacity(), rand_opacity());
    settle();
    apb_write(REG_REGION_WIDTH, 32'd2);
    apb_write(REG_REGION_HEIGHT, 32'd2);
    send(1'b0, 16'd100, 16'd200);
    for (int i = 0; i < 4; i++) send(1'b1, 16'd0, 16'd0);
    settle();

    run_frame(9'd4, 9'd3, 4'd15, 5'b10000, 1'b1, 1'b0);
    run_frame(9'd3, 9'd4, 4'd1, 5'd15, 1'b0, 1'b0);
    run_frame(9'd5, 9'd2, 4'd2, 5'b11111, 1'b1, 1'b0);
    run_frame(9'd0, 9'd0, 4'd3, 5'd1, 1'b0, 1'b0);
    run_frame(9'd511, 9'd1, 4'd15, 5'd2, 1'b1, 1'b0);
    run_frame(9'd1, 9'd7, 4'd4, 5'b11110, 1'b0, 1'b0);
    run_frame(9'd6, 9'd0, 4'd0, 5'd0, 1'b0, 1'b0);
    run_frame(9'd2, 9'd5, 4'd1, 5'd1, 1'b1, 1'b0);

    while (items_sent < 800) begin
      if (items_sent > 720) quiet = 1;
      w = 9'($urandom_range(1, 6));
      h = 9'($urandom_range(1, 6));
      if ($urandom_range(0, 15) == 0) w = $urandom_range(0, 1) ? 9'd0 : 9'd511;
      if ($urandom_range(0, 15) == 0) h = 9'd0;
      fr = 4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 3));
      gr = 5'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 2));
      if ($urandom_range(0, 1)) gr = -gr;
      if (sb.clamp_dim(int'(w)) * sb.clamp_dim(int'(h)) > 16)
        gr = $urandom_range(0, 1) ? 5'd1 : 5'b11110;
      run_frame(w, h, fr, gr, 1'($urandom_range(0, 1)), 1'b1);
    end

    settle();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("alpha_mask_feather_expand_apply: match");
    else
      $display("alpha_mask_feather_expand_apply: mismatch");
    $finish;
  end

endmodule
